/* rtl/core/qmn_pkg.sv */
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared types of the quaternion multiply and normalize pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

    // Side information that rides along with each item through the root stages
    typedef struct packed {
        logic       zero;   // product length is zero
        logic [3:0] neg;    // sign of each product component (x, y, z, w)
    } t_flags;

endpackage

/* rtl/core/qmn_if.sv */
// ----------------------------------------------------------------------------
// qmn_in_if / qmn_out_if
// Valid/ready channels carrying the two input quaternions and the result.
// ----------------------------------------------------------------------------
interface qmn_in_if #(parameter int N = 16);
    logic                valid;
    logic                ready;
    logic signed [N-1:0] a_x;
    logic signed [N-1:0] a_y;
    logic signed [N-1:0] a_z;
    logic signed [N-1:0] a_w;
    logic signed [N-1:0] b_x;
    logic signed [N-1:0] b_y;
    logic signed [N-1:0] b_z;
    logic signed [N-1:0] b_w;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
    modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

interface qmn_out_if #(parameter int N = 16);
    logic                valid;
    logic                ready;
    logic signed [N-1:0] r_x;
    logic signed [N-1:0] r_y;
    logic signed [N-1:0] r_z;
    logic signed [N-1:0] r_w;
    logic                zero_length;

    modport source (output valid, r_x, r_y, r_z, r_w, zero_length, input ready);
    modport sink   (input valid, r_x, r_y, r_z, r_w, zero_length, output ready);
endinterface

/* rtl/core/quaternion_multiply_normalize_top.sv */
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize_top
// Hamilton product of two Q2.14 quaternions, normalized to unit length.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries the left (a_*) and right (b_*) quaternions; o_out carries the
//   normalized product r_* and zero_length. Both are valid/ready channels; a
//   transfer happens on a clock edge with valid and ready high.
//   Each component is round(1.0 * p / |p|) with ties away from zero. When
//   either input is the zero quaternion the result is zero with zero_length set.
// Pipeline:
//   From input transfer to output valid, three stages form the products, sums
//   and squared length, then one stage per result bit (COMPONENT_BITS - 1) runs
//   the root search, then an output register applies the sign. One item per
//   cycle is accepted while the output side does not stall.
// Reset:
//   i_rst_n (synchronous, active low) empties the pipeline.
// Stall:
//   Every stage holds when the next one is full and held; bubbles collapse,
//   so the pipeline keeps filling until full while o_out.ready is low.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize_top #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    qmn_in_if.sink  i_in,
    qmn_out_if.source o_out
);
    localparam int N = COMPONENT_BITS;
    localparam int K = N - 1;
    localparam int W = 6 * N + 3;
    localparam int M = 2 * N + 1;   // magnitude and norm width

    // ---------------- stage 1: products -----------------
    logic                       r_v1;
    logic [3:0][3:0][2*N-1:0]   r_s1_m;
    logic [3:0][2*N-1:0]        r_s1_sa;
    logic [3:0][2*N-1:0]        r_s1_sb;
    logic [3:0][2*N-1:0]        n_s1_sa;
    logic [3:0][2*N-1:0]        n_s1_sb;
    logic [3:0][3:0][2*N-1:0]   n_s1_m;
    logic signed [N-1:0]        a [4];
    logic signed [N-1:0]        b [4];
    logic                       rdy1, rdy2, rdy3, rdy_o;

    assign a[0] = i_in.a_x;
    assign a[1] = i_in.a_y;
    assign a[2] = i_in.a_z;
    assign a[3] = i_in.a_w;
    assign b[0] = i_in.b_x;
    assign b[1] = i_in.b_y;
    assign b[2] = i_in.b_z;
    assign b[3] = i_in.b_w;

    // Form every cross product a_i * b_j and the squares
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_s1_m[i][j] = (2*N)'(a[i] * b[j]);
            end
            n_s1_sa[i] = (2*N)'(a[i] * a[i]);
            n_s1_sb[i] = (2*N)'(b[i] * b[i]);
        end
    end

    assign rdy1       = !r_v1 || rdy2;
    assign i_in.ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_m  <= n_s1_m;
            r_s1_sa <= n_s1_sa;
            r_s1_sb <= n_s1_sb;
        end
    end

    // ---------------- stage 2: sums -----------------
    logic                  r_v2;
    logic [3:0][M-1:0]     r_s2_mag;
    logic [M-1:0]          r_s2_na;
    logic [M-1:0]          r_s2_nb;
    qmn_pkg::t_flags       r_s2_flags;
    logic signed [M:0]     p [4];
    logic [3:0][M-1:0]     n_s2_mag;
    logic [M-1:0]          n_s2_na;
    logic [M-1:0]          n_s2_nb;
    qmn_pkg::t_flags       n_s2_flags;

    // Combine cross products into the Hamilton product (x, y, z, w)
    always_comb begin
        p[0] = $signed(r_s1_m[0][3]) + $signed(r_s1_m[1][2])
             - $signed(r_s1_m[2][1]) + $signed(r_s1_m[3][0]);
        p[1] = $signed(r_s1_m[1][3]) + $signed(r_s1_m[2][0])
             + $signed(r_s1_m[3][1]) - $signed(r_s1_m[0][2]);
        p[2] = $signed(r_s1_m[0][1]) - $signed(r_s1_m[1][0])
             + $signed(r_s1_m[2][3]) + $signed(r_s1_m[3][2]);
        p[3] = $signed(r_s1_m[3][3]) - $signed(r_s1_m[0][0])
             - $signed(r_s1_m[1][1]) - $signed(r_s1_m[2][2]);
        for (int k = 0; k < 4; k++) begin
            n_s2_flags.neg[k] = p[k][M];
            n_s2_mag[k]       = p[k][M] ? M'(-p[k]) : M'(p[k]);
        end
        n_s2_na = M'(r_s1_sa[0]) + M'(r_s1_sa[1]) + M'(r_s1_sa[2]) + M'(r_s1_sa[3]);
        n_s2_nb = M'(r_s1_sb[0]) + M'(r_s1_sb[1]) + M'(r_s1_sb[2]) + M'(r_s1_sb[3]);
        n_s2_flags.zero = (n_s2_na == '0) || (n_s2_nb == '0);
    end

    assign rdy2 = !r_v2 || rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_mag   <= n_s2_mag;
            r_s2_na    <= n_s2_na;
            r_s2_nb    <= n_s2_nb;
            r_s2_flags <= n_s2_flags;
        end
    end

    // ---------------- stage 3: squared length and targets -----------------
    logic                  r_v3;
    logic [W-1:0]          r_s3_p;
    logic [3:0][W-1:0]     r_s3_r;
    qmn_pkg::t_flags       r_s3_flags;
    logic [2*M-1:0]        len2;
    logic [2*M-1:0]        msq;
    logic [W-1:0]          n_s3_p;
    logic [3:0][W-1:0]     n_s3_r;

    // P = |a|^2 |b|^2, residue = (2^(N-1) * mag)^2 - P
    always_comb begin
        len2   = (2*M)'(r_s2_na) * (2*M)'(r_s2_nb);
        n_s3_p = W'(len2);
        for (int k = 0; k < 4; k++) begin
            msq       = (2*M)'(r_s2_mag[k]) * (2*M)'(r_s2_mag[k]);
            n_s3_r[k] = (W'(msq) << (2 * N - 2)) - n_s3_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_p     <= n_s3_p;
            r_s3_r     <= n_s3_r;
            r_s3_flags <= r_s2_flags;
        end
    end

    // ---------------- root search stages -----------------
    logic                  g_v     [K+1];
    logic                  g_rdy   [K+1];
    logic [W-1:0]          g_p     [K+1];
    logic [3:0][W-1:0]     g_r     [K+1];
    logic [3:0][W-1:0]     g_e     [K+1];
    logic [3:0][N-2:0]     g_c     [K+1];
    qmn_pkg::t_flags       g_flags [K+1];

    // Start with c = 0, so E = (2c - 1) * P = -P
    assign g_v[0]     = r_v3;
    assign rdy3       = !r_v3 || g_rdy[0];
    assign g_p[0]     = r_s3_p;
    assign g_r[0]     = r_s3_r;
    assign g_flags[0] = r_s3_flags;
    assign g_e[0]     = {4{W'(0) - r_s3_p}};
    assign g_c[0]     = '0;

    for (genvar s = 0; s < K; s++) begin : g_step
        qmn_step #(
            .N (N),
            .J (K - 1 - s)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (g_v[s]),
            .o_ready (g_rdy[s]),
            .i_p     (g_p[s]),
            .i_r     (g_r[s]),
            .i_e     (g_e[s]),
            .i_c     (g_c[s]),
            .i_flags (g_flags[s]),
            .o_valid (g_v[s+1]),
            .i_ready (g_rdy[s+1]),
            .o_p     (g_p[s+1]),
            .o_r     (g_r[s+1]),
            .o_e     (g_e[s+1]),
            .o_c     (g_c[s+1]),
            .o_flags (g_flags[s+1])
        );
    end

    // ---------------- output register -----------------
    logic                  r_ov;
    logic [3:0][N-1:0]     r_oq;
    logic                  r_ozero;
    logic [3:0][N-1:0]     n_oq;

    assign g_rdy[K] = rdy_o;
    assign rdy_o    = !r_ov || o_out.ready;

    // Apply the sign; force zero when the length is zero
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (g_flags[K].zero) begin
                n_oq[k] = '0;
            end else if (g_flags[K].neg[k]) begin
                n_oq[k] = N'(0) - N'(g_c[K][k]);
            end else begin
                n_oq[k] = N'(g_c[K][k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= g_v[K];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_oq    <= n_oq;
            r_ozero <= g_flags[K].zero;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.r_x         = r_oq[0];
    assign o_out.r_y         = r_oq[1];
    assign o_out.r_z         = r_oq[2];
    assign o_out.r_w         = r_oq[3];
    assign o_out.zero_length = r_ozero;

    // ---------------- assertions -----------------
    localparam logic signed [N-1:0] OneQ = N'(1) << (N - 2);

    // A zero-length result carries all-zero components
    a_zero_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_length |->
        o_out.r_x == '0 && o_out.r_y == '0 && o_out.r_z == '0 && o_out.r_w == '0)
        else $error("zero-length result with nonzero component");

    // Normalized components never exceed 1.0 in magnitude
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
        o_out.r_x <= OneQ && o_out.r_x >= -OneQ && o_out.r_y <= OneQ && o_out.r_y >= -OneQ &&
        o_out.r_z <= OneQ && o_out.r_z >= -OneQ && o_out.r_w <= OneQ && o_out.r_w >= -OneQ)
        else $error("normalized component out of range");

    // A free output side lets the whole pipeline take input
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output is ready");

endmodule

/* rtl/core/qmn_step.sv */
// ----------------------------------------------------------------------------
// qmn_step
// One pipeline stage of the normalizing root search: decides result bit J
// of all four components with an add-and-compare on the running residue.
// ----------------------------------------------------------------------------
module qmn_step #(
    parameter int N = 16,
    parameter int J = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [6*N+2:0]                 i_p,
    input  logic [3:0][6*N+2:0]            i_r,
    input  logic [3:0][6*N+2:0]            i_e,
    input  logic [3:0][N-2:0]              i_c,
    input  qmn_pkg::t_flags                i_flags,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [6*N+2:0]                 o_p,
    output logic [3:0][6*N+2:0]            o_r,
    output logic [3:0][6*N+2:0]            o_e,
    output logic [3:0][N-2:0]              o_c,
    output qmn_pkg::t_flags                o_flags
);
    localparam int W = 6 * N + 3;

    logic                r_valid;
    logic [W-1:0]        r_p;
    logic [3:0][W-1:0]   r_r;
    logic [3:0][W-1:0]   r_e;
    logic [3:0][N-2:0]   r_c;
    qmn_pkg::t_flags     r_flags;

    logic [3:0][W-1:0]   n_r;
    logic [3:0][W-1:0]   n_e;
    logic [3:0][N-2:0]   n_c;
    logic                load;

    // Take this stage when it is empty or its content moves on
    assign o_ready = !r_valid || i_ready;
    assign load    = o_ready;

    // Try setting bit J: residue minus (2^(J+2)*E + 2^(2J+2)*P) must stay >= 0
    always_comb begin
        logic [W-1:0] delta;
        logic [W-1:0] rem;
        for (int k = 0; k < 4; k++) begin
            delta  = (i_e[k] << (J + 2)) + (i_p << (2 * J + 2));
            rem    = i_r[k] - delta;
            n_r[k] = i_r[k];
            n_e[k] = i_e[k];
            n_c[k] = i_c[k];
            if (!rem[W-1]) begin
                n_r[k]    = rem;
                n_e[k]    = i_e[k] + (i_p << (J + 1));
                n_c[k][J] = 1'b1;
            end
        end
    end

    // Hold valid under reset, advance on load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p     <= i_p;
            r_r     <= n_r;
            r_e     <= n_e;
            r_c     <= n_c;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_r     = r_r;
    assign o_e     = r_e;
    assign o_c     = r_c;
    assign o_flags = r_flags;

endmodule
